// ----- rtl/core/pit_pkg.sv -----
`default_nettype none

package pit_pkg;

	localparam int NUM_CHANNELS = 3;
	localparam int COUNT_WIDTH  = 16;

	// request kinds
	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_TICK  = 2'd2;

	localparam logic [1:0] PORT_CONTROL = 2'd3;

	// select field of a control word
	localparam logic [1:0] SC_READBACK = 2'd3;

	// access field of a control word
	localparam logic [1:0] RW_LATCH = 2'd0;
	localparam logic [1:0] RW_LSB   = 2'd1;
	localparam logic [1:0] RW_MSB   = 2'd2;
	localparam logic [1:0] RW_WORD  = 2'd3;

	typedef logic [COUNT_WIDTH-1:0] count_t;

	// per-channel command for one transaction
	typedef struct packed {
		logic       prog;
		logic       latch_cnt;
		logic       latch_sts;
		logic       wr;
		logic       rd;
		logic       tick;
		logic       gate;
		logic [7:0] data;
	} pit_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/core/programmable_interval_timer.sv -----
// Three-channel 16-bit interval timer (rate generator and square wave modes).
// Input channel (in_valid/in_stall): one transaction is a bus write, a bus read
// or one timer clock tick carrying the gate level of every channel. Port 3
// takes control words (program, counter latch, read-back); ports 0..2 load
// counts and return counts or latched status through the byte toggle.
// Output channel (out_valid/out_stall): exactly one result per transaction,
// in order: read_byte/read_valid for a read, and the OUT level of every
// channel after the transaction in out_levels.
// Timing: a transaction passes through the input register, then its result
// goes to the result register, where out_valid rises; a result stall holds it
// in the input register. Throughput: one transaction per cycle while out_stall
// is low; the channel state update is a single pass between the two registers.
// When out_stall is high with a result waiting, the input register holds any
// transaction it has and in_stall is high while it is full; nothing is dropped.
// Reset (arst_n low) empties both registers, sets every OUT high with null
// count set, clears control words, toggles and latches, zeroes count elements.
// Reloads are unknown until written; no channel counts before its first count.
`default_nettype none

module programmable_interval_timer
	import pit_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [1:0] req_type,
	input  wire logic [1:0] port_select,
	input  wire logic [7:0] write_byte,
	input  wire logic [2:0] gate_levels,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      read_byte,
	output logic            read_valid,
	output logic [2:0]      out_levels
);

	logic       valid_s1;
	logic [1:0] req_s1;
	logic [1:0] port_s1;
	logic [7:0] byte_s1;
	logic [2:0] gate_s1;

	logic       out_valid_q;
	logic [7:0] read_byte_q;
	logic       read_valid_q;
	logic [2:0] out_levels_q;

	logic       advance;
	logic       accept;
	pit_cmd_t   cmd [NUM_CHANNELS];
	logic [7:0] ch_byte [NUM_CHANNELS];
	logic       ch_level [NUM_CHANNELS];
	logic [7:0] byte_mux;
	logic       rd_any;
	logic [2:0] levels;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1  <= req_type;
			port_s1 <= port_select;
			byte_s1 <= write_byte;
			gate_s1 <= gate_levels;
		end
	end

	pit_decode u_decode (
		.fire        (advance),
		.req_type    (req_s1),
		.port_select (port_s1),
		.write_byte  (byte_s1),
		.gate_levels (gate_s1),
		.cmd         (cmd)
	);

	for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_ch
		pit_channel u_channel (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd[c]),
			.rd_byte    (ch_byte[c]),
			.level_next (ch_level[c])
		);
	end

	always_comb begin
		byte_mux = 8'h00;
		rd_any   = 1'b0;
		levels   = 3'b000;
		for (int c = 0; c < NUM_CHANNELS; c++) begin
			byte_mux  = byte_mux | ch_byte[c];
			rd_any    = rd_any | cmd[c].rd;
			levels[c] = ch_level[c];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			read_byte_q  <= byte_mux;
			read_valid_q <= rd_any;
			out_levels_q <= levels;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_byte  = read_byte_q;
	assign read_valid = read_valid_q;
	assign out_levels = out_levels_q;

endmodule

`default_nettype wire

// ----- rtl/core/pit_decode.sv -----
`default_nettype none

module pit_decode
	import pit_pkg::*;
(
	input  wire logic       fire,
	input  wire logic [1:0] req_type,
	input  wire logic [1:0] port_select,
	input  wire logic [7:0] write_byte,
	input  wire logic [2:0] gate_levels,
	output pit_cmd_t        cmd [NUM_CHANNELS]
);

	logic       ctl_wr;
	logic [1:0] sc;
	logic [1:0] rw;

	assign ctl_wr = fire && (req_type == REQ_WRITE) && (port_select == PORT_CONTROL);
	assign sc     = write_byte[7:6];
	assign rw     = write_byte[5:4];

	always_comb begin
		for (int c = 0; c < NUM_CHANNELS; c++) begin
			cmd[c]           = '0;
			cmd[c].data      = write_byte;
			cmd[c].gate      = gate_levels[c];
			cmd[c].tick      = fire && (req_type == REQ_TICK);
			cmd[c].wr        = fire && (req_type == REQ_WRITE) && (port_select == 2'(c));
			cmd[c].rd        = fire && (req_type == REQ_READ) && (port_select == 2'(c));
			if (ctl_wr) begin
				if (sc == SC_READBACK) begin
					if (write_byte[c+1]) begin
						cmd[c].latch_cnt = !write_byte[5];
						cmd[c].latch_sts = !write_byte[4];
					end
				end else if (sc == 2'(c)) begin
					if (rw == RW_LATCH) begin
						cmd[c].latch_cnt = 1'b1;
					end else begin
						cmd[c].prog = 1'b1;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/pit_channel.sv -----
`default_nettype none

module pit_channel
	import pit_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire pit_cmd_t cmd,
	output logic [7:0]    rd_byte,
	output logic          level_next
);

	count_t      reload_q;
	count_t      ce_q, ce_d;
	count_t      olatch_q, olatch_d;
	logic        cnt_lat_q, cnt_lat_d;
	logic [7:0]  sts_q, sts_d;
	logic        sts_lat_q, sts_lat_d;
	logic [5:0]  ctrl_q, ctrl_d;
	logic [1:0]  tog_q, tog_d;
	logic        out_q, out_d;
	logic        null_q, null_d;
	logic        pgate_q, pgate_d;
	logic        armed_q, armed_d;
	logic        pend_q, pend_d;
	logic        oddw_q, oddw_d;

	logic        reload_we;
	logic [15:0] reload_new;
	logic [15:0] reload16;
	logic [15:0] src16;
	count_t      rld_val;
	count_t      ce_dec1;
	count_t      ce_dec2;
	logic        active;
	logic        sq;
	logic [1:0]  rw;
	logic        rising;

	assign active   = ctrl_q[2];
	assign sq       = ctrl_q[1];
	assign rw       = ctrl_q[5:4];
	assign reload16 = 16'(reload_q);
	assign rld_val  = sq ? (reload_q & ~COUNT_WIDTH'(1)) : reload_q;
	assign ce_dec1  = ce_q - COUNT_WIDTH'(1);
	assign ce_dec2  = ce_q - COUNT_WIDTH'(2);
	assign rising   = cmd.gate && !pgate_q;
	assign src16    = cnt_lat_q ? 16'(olatch_q) : 16'(ce_q);

	always_comb begin
		ce_d       = ce_q;
		olatch_d   = olatch_q;
		cnt_lat_d  = cnt_lat_q;
		sts_d      = sts_q;
		sts_lat_d  = sts_lat_q;
		ctrl_d     = ctrl_q;
		tog_d      = tog_q;
		out_d      = out_q;
		null_d     = null_q;
		pgate_d    = pgate_q;
		armed_d    = armed_q;
		pend_d     = pend_q;
		oddw_d     = oddw_q;
		reload_we  = 1'b0;
		reload_new = 16'h0000;
		rd_byte    = 8'h00;

		if (cmd.prog) begin
			ctrl_d    = cmd.data[5:0];
			tog_d     = 2'b00;
			cnt_lat_d = 1'b0;
			sts_lat_d = 1'b0;
			out_d     = 1'b1;
			null_d    = 1'b1;
			armed_d   = 1'b0;
			pend_d    = 1'b0;
			oddw_d    = 1'b0;
		end

		if (cmd.latch_cnt && !cnt_lat_q) begin
			olatch_d  = ce_q;
			cnt_lat_d = 1'b1;
		end

		if (cmd.latch_sts && !sts_lat_q) begin
			sts_d     = {out_q, null_q, ctrl_q};
			sts_lat_d = 1'b1;
		end

		if (cmd.wr && rw != RW_LATCH) begin
			reload_we = 1'b1;
			case (rw)
				RW_LSB:  reload_new = {8'h00, cmd.data};
				RW_MSB:  reload_new = {cmd.data, 8'h00};
				default: reload_new = tog_q[1] ? {cmd.data, reload16[7:0]} : {8'h00, cmd.data};
			endcase
			if (rw == RW_WORD && !tog_q[1]) begin
				// hold count state until the high byte lands
				tog_d[1] = 1'b1;
			end else begin
				tog_d[1] = 1'b0;
				null_d   = 1'b1;
				if (!armed_q) begin
					armed_d = 1'b1;
					pend_d  = 1'b1;
				end
			end
		end

		if (cmd.rd) begin
			if (sts_lat_q) begin
				sts_lat_d = 1'b0;
				rd_byte   = sts_q;
			end else if (rw == RW_WORD) begin
				if (!tog_q[0]) begin
					tog_d[0] = 1'b1;
					rd_byte  = src16[7:0];
				end else begin
					tog_d[0]  = 1'b0;
					cnt_lat_d = 1'b0;
					rd_byte   = src16[15:8];
				end
			end else begin
				rd_byte   = (rw == RW_MSB) ? src16[15:8] : src16[7:0];
				cnt_lat_d = 1'b0;
			end
		end

		if (cmd.tick) begin
			pgate_d = cmd.gate;
			if (active && armed_q) begin
				if (!cmd.gate) begin
					out_d = 1'b1;
				end else if (rising || pend_q) begin
					pend_d = 1'b0;
					ce_d   = rld_val;
					null_d = 1'b0;
					oddw_d = 1'b0;
					out_d  = 1'b1;
				end else if (!sq) begin
					if (ce_q == COUNT_WIDTH'(1)) begin
						ce_d   = rld_val;
						null_d = 1'b0;
						oddw_d = 1'b0;
						out_d  = 1'b1;
					end else begin
						ce_d = ce_dec1;
						if (ce_dec1 == COUNT_WIDTH'(1)) out_d = 1'b0;
					end
				end else if (oddw_q) begin
					// extra high clock of an odd count is over
					out_d  = 1'b0;
					ce_d   = rld_val;
					null_d = 1'b0;
					oddw_d = 1'b0;
				end else begin
					ce_d = ce_dec2;
					if (ce_dec2 == '0) begin
						if (out_q && reload_q[0]) begin
							oddw_d = 1'b1;
						end else begin
							out_d  = !out_q;
							ce_d   = rld_val;
							null_d = 1'b0;
							oddw_d = 1'b0;
						end
					end
				end
			end
		end
	end

	assign level_next = out_d;

	always_ff @(posedge clk) begin
		if (reload_we) begin
			reload_q <= reload_new[COUNT_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ce_q      <= '0;
			olatch_q  <= '0;
			cnt_lat_q <= 1'b0;
			sts_q     <= 8'h00;
			sts_lat_q <= 1'b0;
			ctrl_q    <= 6'h00;
			tog_q     <= 2'b00;
			out_q     <= 1'b1;
			null_q    <= 1'b1;
			pgate_q   <= 1'b0;
			armed_q   <= 1'b0;
			pend_q    <= 1'b0;
			oddw_q    <= 1'b0;
		end else begin
			ce_q      <= ce_d;
			olatch_q  <= olatch_d;
			cnt_lat_q <= cnt_lat_d;
			sts_q     <= sts_d;
			sts_lat_q <= sts_lat_d;
			ctrl_q    <= ctrl_d;
			tog_q     <= tog_d;
			out_q     <= out_d;
			null_q    <= null_d;
			pgate_q   <= pgate_d;
			armed_q   <= armed_d;
			pend_q    <= pend_d;
			oddw_q    <= oddw_d;
		end
	end

endmodule

`default_nettype wire

// ----- bench/tb_programmable_interval_timer.sv -----
module tb_programmable_interval_timer
	import pit_pkg::*;
;

	// mode field values of a control word (bits 3..1)
	localparam logic [2:0] MODE_RATE   = 3'd2;
	localparam logic [2:0] MODE_SQUARE = 3'd3;

	localparam int RANDOM_ITEMS = 1150;

	typedef struct packed {
		logic [7:0] rd_byte;
		logic       rd_valid;
		logic [2:0] levels;
	} timer_result_t;

	typedef struct {
		logic [1:0] req;
		logic [1:0] port;
		logic [7:0] data;
		logic [2:0] gates;
	} timer_item_t;

	class timer_scoreboard;
		count_t     reload_val [NUM_CHANNELS];
		count_t     count_elem [NUM_CHANNELS];
		count_t     held_count [NUM_CHANNELS];
		bit         count_held [NUM_CHANNELS];
		logic [7:0] held_status[NUM_CHANNELS];
		bit         status_held[NUM_CHANNELS];
		logic [5:0] ctrl       [NUM_CHANNELS];
		logic [1:0] toggle     [NUM_CHANNELS];
		bit         out_lvl    [NUM_CHANNELS];
		bit         null_cnt   [NUM_CHANNELS];
		bit         prev_gate  [NUM_CHANNELS];
		bit         armed      [NUM_CHANNELS];
		bit         load_pend  [NUM_CHANNELS];
		bit         odd_wait   [NUM_CHANNELS];

		timer_result_t expected_q[$];
		int            fail_count;
		int            results_seen;

		function new();
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				reload_val[c]  = '0;
				count_elem[c]  = '0;
				held_count[c]  = '0;
				count_held[c]  = 0;
				held_status[c] = '0;
				status_held[c] = 0;
				ctrl[c]        = '0;
				toggle[c]      = '0;
				out_lvl[c]     = 1;
				null_cnt[c]    = 1;
				prev_gate[c]   = 0;
				armed[c]       = 0;
				load_pend[c]   = 0;
				odd_wait[c]    = 0;
			end
			fail_count   = 0;
			results_seen = 0;
		endfunction

		function void latch_count(int c);
			if (!count_held[c]) begin
				held_count[c] = count_elem[c];
				count_held[c] = 1;
			end
		endfunction

		function void reload_channel(int c, logic [1:0] m);
			if (m == MODE_SQUARE[1:0])
				count_elem[c] = reload_val[c] & ~count_t'(1);
			else
				count_elem[c] = reload_val[c];
			null_cnt[c] = 0;
			odd_wait[c] = 0;
		endfunction

		// Advance the timer by one accepted transaction and queue its result.
		function void note_transaction(logic [1:0] req, logic [1:0] port, logic [7:0] wb,
				logic [2:0] gates);
			timer_result_t want;
			logic [7:0]    rb;
			logic          rv;
			logic [2:0]    lv;
			logic [1:0]    rw;
			logic [1:0]    m;
			count_t        src;
			count_t        ce;
			bit            commit;
			bit            g;
			bit            rising;
			int            ch;

			rb = '0;
			rv = 0;
			ch = port;
			if (req == REQ_WRITE && port == PORT_CONTROL) begin
				ch = wb[7:6];
				if (wb[7:6] == SC_READBACK) begin
					for (int k = 0; k < NUM_CHANNELS; k++) begin
						if (wb[k+1]) begin
							if (!wb[5])
								latch_count(k);
							if (!wb[4] && !status_held[k]) begin
								held_status[k] = {out_lvl[k], null_cnt[k], ctrl[k]};
								status_held[k] = 1;
							end
						end
					end
				end else if (ch < NUM_CHANNELS) begin
					if (wb[5:4] == RW_LATCH) begin
						latch_count(ch);
					end else begin
						ctrl[ch]        = wb[5:0];
						toggle[ch]      = '0;
						count_held[ch]  = 0;
						status_held[ch] = 0;
						out_lvl[ch]     = 1;
						null_cnt[ch]    = 1;
						armed[ch]       = 0;
						load_pend[ch]   = 0;
						odd_wait[ch]    = 0;
					end
				end
			end else if (req == REQ_WRITE && ch < NUM_CHANNELS) begin
				rw     = ctrl[ch][5:4];
				commit = 1;
				case (rw)
					RW_LATCH: commit = 0;
					RW_LSB:   reload_val[ch] = count_t'(wb);
					RW_MSB:   reload_val[ch] = count_t'({wb, 8'h00});
					default: begin
						if (!toggle[ch][1]) begin
							reload_val[ch] = count_t'(wb);
							toggle[ch][1]  = 1'b1;
							commit         = 0;
						end else begin
							reload_val[ch] = count_t'({wb, reload_val[ch][7:0]});
							toggle[ch][1]  = 1'b0;
						end
					end
				endcase
				if (commit) begin
					null_cnt[ch] = 1;
					if (!armed[ch]) begin
						armed[ch]     = 1;
						load_pend[ch] = 1;
					end
				end
			end else if (req == REQ_READ && port != PORT_CONTROL && ch < NUM_CHANNELS) begin
				rv = 1;
				rw = ctrl[ch][5:4];
				if (status_held[ch]) begin
					status_held[ch] = 0;
					rb = held_status[ch];
				end else begin
					src = count_held[ch] ? held_count[ch] : count_elem[ch];
					if (rw == RW_WORD) begin
						if (!toggle[ch][0]) begin
							toggle[ch][0] = 1'b1;
							rb = src[7:0];
						end else begin
							toggle[ch][0]  = 1'b0;
							count_held[ch] = 0;
							rb = 8'(src >> 8);
						end
					end else begin
						rb = (rw == RW_MSB) ? 8'(src >> 8) : src[7:0];
						count_held[ch] = 0;
					end
				end
			end else if (req == REQ_TICK) begin
				for (int c = 0; c < NUM_CHANNELS; c++) begin
					g            = gates[c];
					rising       = g && !prev_gate[c];
					m            = ctrl[c][2:1];
					ce           = count_elem[c];
					prev_gate[c] = g;
					if ((m != MODE_RATE[1:0] && m != MODE_SQUARE[1:0]) || !armed[c])
						continue;
					if (!g) begin
						out_lvl[c] = 1;
						continue;
					end
					if (rising || load_pend[c]) begin
						load_pend[c] = 0;
						reload_channel(c, m);
						out_lvl[c] = 1;
						continue;
					end
					if (m == MODE_RATE[1:0]) begin
						if (ce == count_t'(1)) begin
							reload_channel(c, m);
							out_lvl[c] = 1;
						end else begin
							ce = ce - count_t'(1);
							count_elem[c] = ce;
							if (ce == count_t'(1))
								out_lvl[c] = 0;
						end
					end else if (odd_wait[c]) begin
						// extra high clock of an odd count is over
						out_lvl[c] = 0;
						reload_channel(c, m);
					end else begin
						ce = ce - count_t'(2);
						count_elem[c] = ce;
						if (ce == '0) begin
							if (out_lvl[c] && reload_val[c][0]) begin
								odd_wait[c] = 1;
							end else begin
								out_lvl[c] = !out_lvl[c];
								reload_channel(c, m);
							end
						end
					end
				end
			end

			lv = '0;
			for (int c = 0; c < NUM_CHANNELS; c++)
				lv[c] = out_lvl[c];
			want.rd_byte  = rb;
			want.rd_valid = rv;
			want.levels   = lv;
			expected_q.push_back(want);
		endfunction

		task report_mismatch(string msg);
			$display("mismatch at result %0d: %s", results_seen, msg);
			fail_count++;
		endtask

		task check_result(logic [7:0] rb, logic rv, logic [2:0] lv);
			timer_result_t want;
			results_seen++;
			if (expected_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result byte %h valid %b out %b", rb, rv, lv));
			end else begin
				want = expected_q.pop_front();
				if (rb !== want.rd_byte)
					report_mismatch($sformatf("read_byte %h, want %h", rb, want.rd_byte));
				if (rv !== want.rd_valid)
					report_mismatch($sformatf("read_valid %b, want %b", rv, want.rd_valid));
				if (lv !== want.levels)
					report_mismatch($sformatf("out_levels %b, want %b", lv, want.levels));
			end
		endtask
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [1:0] req_type;
	logic [1:0] port_select;
	logic [7:0] write_byte;
	logic [2:0] gate_levels;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] read_byte;
	logic       read_valid;
	logic [2:0] out_levels;

	timer_scoreboard sb;
	timer_item_t     stim_q[$];
	int              idle_phase = 0;

	programmable_interval_timer i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.port_select(port_select),
		.write_byte (write_byte),
		.gate_levels(gate_levels),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.read_byte  (read_byte),
		.read_valid (read_valid),
		.out_levels (out_levels)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic bit pick_idle(int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	function automatic void add_item(logic [1:0] req, logic [1:0] port, logic [7:0] data,
			logic [2:0] gates);
		timer_item_t it;
		it.req   = req;
		it.port  = port;
		it.data  = data;
		it.gates = gates;
		stim_q.push_back(it);
	endfunction

	function automatic void add_ticks(int n, logic [2:0] gates);
		repeat (n) add_item(REQ_TICK, 2'd0, 8'h00, gates);
	endfunction

	task automatic drive_transactions();
		int idx;
		idx = 0;
		while (idx < stim_q.size() || in_valid) begin
			@(posedge clk);
			if (in_valid && !in_stall) begin
				sb.note_transaction(req_type, port_select, write_byte, gate_levels);
				idx++;
				idle_phase = (idx / 100) % 4;
			end
			// hold a stalled transaction; otherwise load the next one or idle
			if (!in_valid || !in_stall) begin
				if (idx < stim_q.size() &&
						!pick_idle(idle_phase == 1 ? 68 : (idle_phase == 3 ? 17 : 0))) begin
					in_valid    <= 1'b1;
					req_type    <= stim_q[idx].req;
					port_select <= stim_q[idx].port;
					write_byte  <= stim_q[idx].data;
					gate_levels <= stim_q[idx].gates;
				end else begin
					in_valid    <= 1'b0;
					req_type    <= 2'($urandom);
					port_select <= 2'($urandom);
					write_byte  <= 8'($urandom);
					gate_levels <= 3'($urandom);
				end
			end
		end
	endtask

	always @(posedge clk) begin
		if (out_valid === 1'b1 && out_stall === 1'b0)
			sb.check_result(read_byte, read_valid, out_levels);
		out_stall <= pick_idle(idle_phase == 2 ? 68 : (idle_phase == 3 ? 17 : 0));
	end

	initial begin
		int         n_directed;
		int         scenario;
		int         len;
		int         pick;
		int         ch;
		logic [1:0] rw;
		logic [2:0] mode;
		count_t     cnt_val;

		sb = new();
		in_valid    <= 1'b0;
		req_type    <= REQ_TICK;
		port_select <= 2'd0;
		write_byte  <= 8'h00;
		gate_levels <= 3'b000;
		out_stall   <= 1'b0;
		arst_n      <= 1'b0;

		// unprogrammed channels: no access field, reads give the low byte
		add_item(REQ_READ, 2'd0, 8'h00, 3'b000);
		add_item(REQ_WRITE, 2'd1, 8'hFF, 3'b111);
		add_item(REQ_READ, PORT_CONTROL, 8'h00, 3'b000);
		add_item(REQ_WRITE, PORT_CONTROL, 8'hE2, 3'b000);
		add_item(REQ_READ, 2'd0, 8'h00, 3'b000);
		// channel 2 rate generator, count 3 in two bytes
		add_item(REQ_WRITE, PORT_CONTROL, 8'hB4, 3'b000);
		add_item(REQ_WRITE, 2'd2, 8'h03, 3'b000);
		add_item(REQ_WRITE, 2'd2, 8'h00, 3'b000);
		add_ticks(4, 3'b111);
		add_item(REQ_WRITE, PORT_CONTROL, 8'h80, 3'b000);
		add_ticks(1, 3'b111);
		add_item(REQ_WRITE, PORT_CONTROL, 8'h80, 3'b000);
		add_item(REQ_READ, 2'd2, 8'h00, 3'b000);
		add_item(REQ_READ, 2'd2, 8'h00, 3'b000);
		// square wave with a count of one, gate dropped and raised again
		add_item(REQ_WRITE, PORT_CONTROL, 8'hB6, 3'b000);
		add_item(REQ_WRITE, 2'd2, 8'h01, 3'b000);
		add_item(REQ_WRITE, 2'd2, 8'h00, 3'b000);
		add_ticks(2, 3'b100);
		add_ticks(1, 3'b000);
		add_ticks(1, 3'b100);
		add_item(REQ_WRITE, PORT_CONTROL, 8'h43, 3'b000);
		add_item(REQ_READ, 2'd1, 8'h00, 3'b000);
		add_item(REQ_WRITE, PORT_CONTROL, 8'h40, 3'b000);
		add_item(REQ_WRITE, PORT_CONTROL, 8'hFF, 3'b000);
		// mode 7 on channel 0, low byte only, BCD bit set
		add_item(REQ_WRITE, PORT_CONTROL, 8'h1F, 3'b000);
		add_item(REQ_WRITE, 2'd0, 8'h01, 3'b000);
		add_ticks(2, 3'b001);
		n_directed = stim_q.size();

		while (stim_q.size() < n_directed + RANDOM_ITEMS) begin
			scenario = $urandom_range(0, 99);
			if (scenario < 50) begin
				// program a channel, load a count, then let it run
				ch = $urandom_range(0, NUM_CHANNELS - 1);
				rw = 2'($urandom_range(RW_LSB, RW_WORD));
				if ($urandom_range(0, 3) == 0)
					mode = 3'($urandom);
				else
					mode = {1'($urandom), 1'b1, 1'($urandom)};
				add_item(REQ_WRITE, PORT_CONTROL, {2'(ch), rw, mode, 1'($urandom)},
					3'($urandom));
				if ($urandom_range(0, 9) == 0)
					cnt_val = count_t'($urandom);
				else
					cnt_val = count_t'($urandom_range(1, 14));
				add_item(REQ_WRITE, 2'(ch), cnt_val[7:0], 3'($urandom));
				if (rw == RW_WORD)
					add_item(REQ_WRITE, 2'(ch), 8'(cnt_val >> 8), 3'($urandom));
				len = $urandom_range(8, 40);
				repeat (len) begin
					pick = $urandom_range(0, 99);
					if (pick < 75) begin
						if ($urandom_range(0, 9) == 0)
							add_ticks(1, 3'($urandom));
						else
							add_ticks(1, 3'($urandom) | (3'b001 << ch));
					end else if (pick < 87) begin
						add_item(REQ_READ, 2'(ch), 8'($urandom), 3'($urandom));
					end else if (pick < 93) begin
						add_item(REQ_WRITE, PORT_CONTROL, {2'(ch), RW_LATCH, 4'($urandom)},
							3'($urandom));
					end else if (pick < 97) begin
						add_item(REQ_WRITE, PORT_CONTROL, {SC_READBACK, 6'($urandom)},
							3'($urandom));
					end else begin
						add_item(REQ_WRITE, 2'(ch), 8'($urandom_range(1, 14)), 3'($urandom));
					end
				end
			end else if (scenario < 80) begin
				len = $urandom_range(5, 20);
				repeat (len) begin
					pick = $urandom_range(0, 99);
					if (pick < 60)
						add_ticks(1, 3'($urandom));
					else if (pick < 85)
						add_item(REQ_READ, 2'($urandom), 8'($urandom), 3'($urandom));
					else
						add_item(REQ_WRITE, 2'($urandom), 8'($urandom), 3'($urandom));
				end
			end else begin
				len = $urandom_range(1, 5);
				repeat (len)
					add_item(2'($urandom_range(REQ_WRITE, REQ_TICK)), 2'($urandom),
						8'($urandom), 3'($urandom));
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		drive_transactions();
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (sb.fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
